/* rtl/bms_pkg.sv */
// ----------------------------------------------------------------------------
// bms_pkg: shared types and constants
// Payload structs, store sizes and register indexes for the bucket sorter.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_BITS  = 20;
  localparam int MAX_BUCKETS = 64;
  localparam int CNT_W       = 7;   // holds 0..MAX_ITEMS
  localparam int ADDR_W      = 6;   // store address
  localparam int TAG_W       = 6;
  localparam int NB_W        = 7;   // bucket count register width
  localparam int NUM_W       = VALUE_BITS + NB_W;  // product bucket_count * value
  localparam int STEP_W      = 5;   // divider step counter

  // configuration register indexes
  localparam logic REG_BUCKET_COUNT = 1'b0;
  localparam logic REG_MAX_VALUE    = 1'b1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last_in;
  } in_beat_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] sorted_value;
    logic [TAG_W-1:0]      bucket_index;
    logic                  last_out;
    logic                  overflowed;
  } out_beat_t;

  typedef struct packed {
    logic                  start;
    logic [NUM_W-1:0]      numer;
    logic [VALUE_BITS-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/bms_div.sv */
// ----------------------------------------------------------------------------
// bms_div: iterative restoring divider
// One quotient bit per cycle; done pulses after NUM_W steps.
// ----------------------------------------------------------------------------
module bms_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bms_pkg::div_req_t req,
  output bms_pkg::div_rsp_t rsp
);

  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [bms_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [bms_pkg::VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [bms_pkg::NUM_W-1:0]      quo_r, quo_nxt;
  logic [bms_pkg::VALUE_BITS-1:0] den_r, den_nxt;
  logic [bms_pkg::VALUE_BITS:0]   rem_sh;
  logic [bms_pkg::VALUE_BITS:0]   rem_sub;

  // one shift-subtract step
  always_comb begin
    rem_sh  = {rem_r, quo_r[bms_pkg::NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // step sequencing
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = req.numer;
      den_nxt  = req.denom;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sub[bms_pkg::VALUE_BITS-1:0];
        quo_nxt = {quo_r[bms_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[bms_pkg::VALUE_BITS-1:0];
        quo_nxt = {quo_r[bms_pkg::NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == bms_pkg::STEP_W'(bms_pkg::NUM_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

/* rtl/bucket_merge_sorter.sv */
// ----------------------------------------------------------------------------
// bucket_merge_sorter: bucket sort with stable ascending order per bucket
// Tags each value with its bucket and keeps the store sorted by (tag, value).
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data and raise start; the beat is taken when busy is low.
//   Each value gets bucket floor(bucket_count*value/top_value), clamped to
//   bucket_count-1, from a one-bit-per-cycle divider, then is inserted into
//   a 64-entry store kept in order by walking down from the tail.
//   The tag comes from the multiply and divide states; then each larger
//   entry moves up one place in turn. A beat arriving with the store full
//   is dropped and sets the overflow flag.
//   After a beat with last_in set, every stored value leaves on out_data with
//   out_valid high for one cycle, each from its own store read (single store
//   read port with registered read data); last_out marks the final one and
//   overflowed is set on all results of a set that dropped values.
//   The receiver cannot stall: results are pushed out as produced.
//   Configure via cfg_we/cfg_index/cfg_data only while idle (not enforced).
//   Reset (rst_n low, synchronous) empties the store and sets bucket_count
//   to 1 and the value limit register to 1048575.
// ----------------------------------------------------------------------------
module bucket_merge_sorter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  bms_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  output bms_pkg::out_beat_t             out_data,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [bms_pkg::VALUE_BITS-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_INS    = 3'd3;
  localparam logic [2:0] ST_CMP    = 3'd4;
  localparam logic [2:0] ST_EMRD   = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  localparam int ENT_W = bms_pkg::TAG_W + bms_pkg::VALUE_BITS;

  logic [2:0]                     state_r, state_nxt;
  logic [bms_pkg::NB_W-1:0]       nb_cfg_r;
  logic [bms_pkg::VALUE_BITS-1:0] mv_cfg_r;
  logic [bms_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                           ovf_r, ovf_nxt;
  logic                           last_r, last_nxt;
  logic [bms_pkg::VALUE_BITS-1:0] val_r, val_nxt;
  logic [bms_pkg::NUM_W-1:0]      prod_r, prod_nxt;
  logic [ENT_W-1:0]               key_r, key_nxt;
  logic [bms_pkg::CNT_W-1:0]      ptr_r, ptr_nxt;
  logic [bms_pkg::NB_W-1:0]       nb_eff;
  logic [bms_pkg::VALUE_BITS-1:0] mv_eff;
  logic [bms_pkg::TAG_W-1:0]      tag;
  logic [bms_pkg::NB_W-1:0]       nb_m1;
  logic                           accept;
  bms_pkg::div_req_t              div_req;
  bms_pkg::div_rsp_t              div_rsp;

  logic [ENT_W-1:0]               mem [bms_pkg::MAX_ITEMS];
  logic [ENT_W-1:0]               rd_data_r;
  logic [bms_pkg::ADDR_W-1:0]     rd_addr;
  logic [bms_pkg::ADDR_W-1:0]     wr_addr;
  logic [ENT_W-1:0]               wr_data;
  logic                           wr_en;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // effective register values: zero and out-of-range bucket counts saturate
  always_comb begin
    nb_eff = nb_cfg_r;
    if (nb_cfg_r == '0) nb_eff = bms_pkg::NB_W'(1);
    else if (nb_cfg_r > bms_pkg::NB_W'(bms_pkg::MAX_BUCKETS))
      nb_eff = bms_pkg::NB_W'(bms_pkg::MAX_BUCKETS);
    mv_eff = (mv_cfg_r == '0) ? bms_pkg::VALUE_BITS'(1) : mv_cfg_r;
    nb_m1  = nb_eff - 1'b1;
  end

  // clamp the quotient to the last bucket
  always_comb begin
    if (div_rsp.quot >= bms_pkg::NUM_W'(nb_eff)) tag = nb_m1[bms_pkg::TAG_W-1:0];
    else tag = div_rsp.quot[bms_pkg::TAG_W-1:0];
  end

  assign div_req.start = (state_r == ST_MUL);
  assign div_req.numer = prod_r;
  assign div_req.denom = mv_eff;

  bms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    val_nxt   = val_r;
    prod_nxt  = prod_r;
    key_nxt   = key_r;
    ptr_nxt   = ptr_r;
    wr_en     = 1'b0;
    wr_addr   = ptr_r[bms_pkg::ADDR_W-1:0];
    wr_data   = key_r;
    rd_addr   = ptr_r[bms_pkg::ADDR_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          val_nxt  = in_data.value;
          last_nxt = in_data.last_in;
          if (count_r == bms_pkg::CNT_W'(bms_pkg::MAX_ITEMS)) begin
            ovf_nxt = 1'b1;
            ptr_nxt = '0;
            if (in_data.last_in) state_nxt = ST_EMRD;
          end else begin
            // product is ready when the divider starts
            prod_nxt  = bms_pkg::NUM_W'(nb_eff) * bms_pkg::NUM_W'(in_data.value);
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          key_nxt   = {tag, val_r};
          ptr_nxt   = count_r;
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        // read the entry below the hole, or drop the key at the bottom
        rd_addr = ptr_r[bms_pkg::ADDR_W-1:0] - 1'b1;
        if (ptr_r == '0) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          ptr_nxt   = '0;
          state_nxt = last_r ? ST_EMRD : ST_IDLE;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        wr_en = 1'b1;
        if (rd_data_r > key_r) begin
          wr_data   = rd_data_r;
          ptr_nxt   = ptr_r - 1'b1;
          state_nxt = ST_INS;
        end else begin
          count_nxt = count_r + 1'b1;
          ptr_nxt   = '0;
          state_nxt = last_r ? ST_EMRD : ST_IDLE;
        end
      end
      ST_EMRD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_nxt == count_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result beat straight from the registered store read
  assign out_valid             = (state_r == ST_EMIT);
  assign out_data.sorted_value = rd_data_r[bms_pkg::VALUE_BITS-1:0];
  assign out_data.bucket_index = rd_data_r[ENT_W-1:bms_pkg::VALUE_BITS];
  assign out_data.last_out     = (ptr_r + 1'b1 == count_r);
  assign out_data.overflowed   = ovf_r;

  // value/tag store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      nb_cfg_r <= bms_pkg::NB_W'(1);
      mv_cfg_r <= {bms_pkg::VALUE_BITS{1'b1}};
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_we && cfg_index == bms_pkg::REG_BUCKET_COUNT)
        nb_cfg_r <= cfg_data[bms_pkg::NB_W-1:0];
      if (cfg_we && cfg_index == bms_pkg::REG_MAX_VALUE)
        mv_cfg_r <= cfg_data;
    end
    last_r <= last_nxt;
    val_r  <= val_nxt;
    prod_r <= prod_nxt;
    key_r  <= key_nxt;
    ptr_r  <= ptr_nxt;
  end

`ifndef ASSERT_OFF
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat while idle");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bms_pkg::CNT_W'(bms_pkg::MAX_ITEMS)) else $error("store count overrun");
  a_full_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && count_r == bms_pkg::CNT_W'(bms_pkg::MAX_ITEMS)) |=> ovf_r)
    else $error("drop not flagged");
  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_out) |=> (count_r == '0 && !ovf_r && !busy))
    else $error("set not cleared after final beat");
`endif

endmodule
